@@ sv/imu_dma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU deadband moving average: shared package
// Types, sizes and constants used by the ring store, the arithmetic unit and
// the top level.
// ----------------------------------------------------------------------------
package imu_dma_pkg;

    localparam int SAMPLES      = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int NFIELDS      = 7;
    localparam int CFG_BITS     = 16;
    localparam int SAMPLE_SHIFT = $clog2(SAMPLES);
    localparam int ROW_W        = SAMPLE_SHIFT;
    localparam int FIELD_W      = 3;
    localparam int ADDR_W       = ROW_W + FIELD_W;
    localparam int ACC_W        = SAMPLE_BITS + SAMPLE_SHIFT;
    localparam int CFG_IDX_W    = 2;

    localparam logic [FIELD_W-1:0] FIELD_RATE_X = FIELD_W'(3);
    localparam logic [FIELD_W-1:0] FIELD_RATE_Z = FIELD_W'(5);
    localparam logic [FIELD_W-1:0] FIELD_LAST   = FIELD_W'(NFIELDS - 1);
    localparam logic [ROW_W-1:0]   ROW_LAST     = ROW_W'(SAMPLES - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_INTERVAL  = 2'd2;

    localparam logic OP_PRIME  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic    opcode;
        t_sample accel_x;
        t_sample accel_y;
        t_sample accel_z;
        t_sample rate_x;
        t_sample rate_y;
        t_sample rate_z;
        t_sample temperature;
    } t_imu_in;

    typedef struct packed {
        t_sample avg_accel_x;
        t_sample avg_accel_y;
        t_sample avg_accel_z;
        t_sample avg_rate_x;
        t_sample avg_rate_y;
        t_sample avg_rate_z;
        t_sample avg_temperature;
        logic    refreshed;
    } t_imu_out;

    typedef struct packed {
        logic add;
        logic first;
    } t_acc_ctl;

endpackage

@@ sv/imu_deadband_moving_average_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU deadband moving average unit
// Each transaction returns the held per-field average of the last SAMPLES
// samples. A normal sample writes its seven fields into the ring; when the
// average is recomputed, each of the seven fields is summed over the
// sixteen ring entries through one adder and one memory read port. A
// prime transaction writes all 112 ring entries one per cycle. Input is
// accepted only while the sequencer is idle; a finished result waits in
// the output register while the next transaction is taken.
// ----------------------------------------------------------------------------
module imu_deadband_moving_average_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  imu_dma_pkg::t_imu_in               i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output imu_dma_pkg::t_imu_out              o_out_data,
    input  logic                               i_cfg_we,
    input  logic [imu_dma_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [imu_dma_pkg::CFG_BITS-1:0]   i_cfg_data
);
    import imu_dma_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_WRITE,
        S_SUM,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                 r_state;
    t_imu_in                r_in;
    logic [FIELD_W-1:0]     r_field;
    logic [ROW_W-1:0]       r_row;
    logic [ROW_W-1:0]       r_slot;
    logic [CFG_BITS-1:0]    r_interval;
    logic [CFG_BITS-1:0]    r_db_low;
    logic [CFG_BITS-1:0]    r_db_high;
    logic [CFG_BITS-1:0]    r_avg_interval;
    t_sample                r_held [NFIELDS];
    logic                   r_refreshed;
    logic                   r_out_valid;
    t_imu_out               r_out;
    t_acc_ctl               r_acc_ctl;

    t_sample                w_field_val;
    t_sample                w_filtered;
    t_sample                w_mean;
    t_sample                w_rdata;
    logic                   w_we;
    logic                   w_re;
    logic [ADDR_W-1:0]      w_waddr;
    logic [ADDR_W-1:0]      w_raddr;
    t_sample                w_wdata;
    logic                   w_filter_en;

    always_comb begin
        case (r_field)
            3'd0:    w_field_val = r_in.accel_x;
            3'd1:    w_field_val = r_in.accel_y;
            3'd2:    w_field_val = r_in.accel_z;
            3'd3:    w_field_val = r_in.rate_x;
            3'd4:    w_field_val = r_in.rate_y;
            3'd5:    w_field_val = r_in.rate_z;
            3'd6:    w_field_val = r_in.temperature;
            default: w_field_val = '0;
        endcase
    end

    always_comb begin
        w_filter_en = (r_field >= FIELD_RATE_X) && (r_field <= FIELD_RATE_Z);
        w_we        = (r_state == S_PRIME) || (r_state == S_WRITE);
        w_waddr     = (r_state == S_PRIME) ? {r_row, r_field} : {r_slot, r_field};
        w_wdata     = (r_state == S_PRIME) ? w_field_val : w_filtered;
        w_re        = (r_state == S_SUM);
        w_raddr     = {r_row, r_field};
    end

    imu_dma_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    imu_dma_alu u_alu (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (w_field_val),
        .i_filter_en (w_filter_en),
        .i_db_low    (r_db_low),
        .i_db_high   (r_db_high),
        .o_filtered  (w_filtered),
        .i_acc_ctl   (r_acc_ctl),
        .i_rdata     (w_rdata),
        .o_mean      (w_mean)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_field        <= '0;
            r_row          <= '0;
            r_slot         <= '0;
            r_interval     <= '0;
            r_db_low       <= CFG_BITS'(0);
            r_db_high      <= CFG_BITS'(32768);
            r_avg_interval <= CFG_BITS'(10);
            r_refreshed    <= 1'b0;
            r_out_valid    <= 1'b0;
            r_acc_ctl      <= '0;
            for (int i = 0; i < NFIELDS; i++) begin
                r_held[i] <= '0;
            end
        end else begin
            if (r_state != S_SUM) begin
                r_acc_ctl <= '0;
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEADBAND_LOW:  r_db_low       <= i_cfg_data;
                    CFG_DEADBAND_HIGH: r_db_high      <= i_cfg_data;
                    CFG_AVG_INTERVAL:  r_avg_interval <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_field <= '0;
                        r_row   <= '0;
                        r_state <= (i_in_data.opcode == OP_SAMPLE) ? S_WRITE : S_PRIME;
                    end
                end
                S_PRIME: begin
                    if (r_field == FIELD_LAST) begin
                        r_field <= '0;
                        if (r_row == ROW_LAST) begin
                            r_row       <= '0;
                            r_held[0]   <= r_in.accel_x;
                            r_held[1]   <= r_in.accel_y;
                            r_held[2]   <= r_in.accel_z;
                            r_held[3]   <= r_in.rate_x;
                            r_held[4]   <= r_in.rate_y;
                            r_held[5]   <= r_in.rate_z;
                            r_held[6]   <= r_in.temperature;
                            r_refreshed <= 1'b0;
                            r_state     <= S_DONE;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_field <= r_field + 1'b1;
                    end
                end
                S_WRITE: begin
                    if (r_field == FIELD_LAST) begin
                        r_field <= '0;
                        r_row   <= '0;
                        r_slot  <= (r_slot == ROW_LAST) ? '0 : r_slot + 1'b1;
                        if (r_interval < r_avg_interval) begin
                            r_interval  <= r_interval + 1'b1;
                            r_refreshed <= 1'b0;
                            r_state     <= S_DONE;
                        end else begin
                            r_interval  <= '0;
                            r_refreshed <= 1'b1;
                            r_state     <= S_SUM;
                        end
                    end else begin
                        r_field <= r_field + 1'b1;
                    end
                end
                S_SUM: begin
                    r_acc_ctl.add   <= 1'b1;
                    r_acc_ctl.first <= (r_row == '0);
                    if (r_row == ROW_LAST) begin
                        r_row   <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_held[r_field] <= w_mean;
                    if (r_field == FIELD_LAST) begin
                        r_field <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_field <= r_field + 1'b1;
                        r_state <= S_SUM;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.avg_accel_x     <= r_held[0];
                        r_out.avg_accel_y     <= r_held[1];
                        r_out.avg_accel_z     <= r_held[2];
                        r_out.avg_rate_x      <= r_held[3];
                        r_out.avg_rate_y      <= r_held[4];
                        r_out.avg_rate_z      <= r_held[5];
                        r_out.avg_temperature <= r_held[6];
                        r_out.refreshed       <= r_refreshed;
                        r_out_valid           <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ sv/imu_dma_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU deadband moving average: sample ring store
// One write port and one registered read port. Rows never written since
// reset read as zero through a valid bit per row.
// ----------------------------------------------------------------------------
module imu_dma_ring (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [imu_dma_pkg::ADDR_W-1:0] i_waddr,
    input  imu_dma_pkg::t_sample         i_wdata,
    input  logic                         i_re,
    input  logic [imu_dma_pkg::ADDR_W-1:0] i_raddr,
    output imu_dma_pkg::t_sample         o_rdata
);
    import imu_dma_pkg::*;

    t_sample              r_mem [SAMPLES*(2**FIELD_W)];
    t_sample              r_rdata;
    logic                 r_rvalid;
    logic [SAMPLES-1:0]   r_row_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rvalid    <= 1'b0;
        end else begin
            if (i_we) begin
                r_row_valid[i_waddr[ADDR_W-1:FIELD_W]] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_row_valid[i_raddr[ADDR_W-1:FIELD_W]];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

@@ sv/imu_dma_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU deadband moving average: shared arithmetic unit
// Gyro deadband filter for the field being written, and the accumulator
// that sums one field over the ring and yields its floor mean.
// ----------------------------------------------------------------------------
module imu_dma_alu (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  imu_dma_pkg::t_sample            i_sample,
    input  logic                            i_filter_en,
    input  logic [imu_dma_pkg::CFG_BITS-1:0] i_db_low,
    input  logic [imu_dma_pkg::CFG_BITS-1:0] i_db_high,
    output imu_dma_pkg::t_sample            o_filtered,
    input  imu_dma_pkg::t_acc_ctl           i_acc_ctl,
    input  imu_dma_pkg::t_sample            i_rdata,
    output imu_dma_pkg::t_sample            o_mean
);
    import imu_dma_pkg::*;

    logic [SAMPLE_BITS:0]       w_ext;
    logic [SAMPLE_BITS:0]       w_mag;
    logic                       w_reject;
    logic signed [ACC_W-1:0]    w_addend;
    logic signed [ACC_W-1:0]    w_sum;
    logic signed [ACC_W-1:0]    r_acc;

    always_comb begin
        w_ext    = {i_sample[SAMPLE_BITS-1], i_sample};
        w_mag    = i_sample[SAMPLE_BITS-1] ? ((SAMPLE_BITS+1)'(0) - w_ext) : w_ext;
        w_reject = (w_mag < (SAMPLE_BITS+1)'(i_db_low)) ||
                   (w_mag > (SAMPLE_BITS+1)'(i_db_high));
        o_filtered = (i_filter_en && w_reject) ? '0 : i_sample;
    end

    always_comb begin
        w_addend = {{SAMPLE_SHIFT{i_rdata[SAMPLE_BITS-1]}}, i_rdata};
        w_sum    = i_acc_ctl.first ? w_addend : (r_acc + w_addend);
        o_mean   = w_sum[ACC_W-1:SAMPLE_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_acc_ctl.add) begin
            r_acc <= w_sum;
        end
    end

endmodule

@@ sim/tb_imu_deadband_moving_average_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the IMU deadband moving average unit
// Drives directed and random IMU samples and prime transactions through the
// unit, with random gaps on both channels. The configuration changes between
// phases, and each returned average is checked against an independent
// model of the ring, the deadband filter and the floor mean.
// ----------------------------------------------------------------------------
module tb_imu_deadband_moving_average_unit;

    import imu_dma_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 124;

    class imu_average_predictor;
        logic [CFG_BITS-1:0] deadband_low;
        logic [CFG_BITS-1:0] deadband_high;
        logic [CFG_BITS-1:0] average_interval;
        t_sample             ring [SAMPLES][NFIELDS];
        t_sample             held [NFIELDS];
        int                  slot;
        logic [15:0]         interval_count;
        t_imu_out            expected_averages [$];
        int                  mismatches;

        function new();
            deadband_low     = '0;
            deadband_high    = 16'd32768;
            average_interval = 16'd10;
            slot             = 0;
            interval_count   = '0;
            mismatches       = 0;
            foreach (ring[k, f]) ring[k][f] = '0;
            foreach (held[f]) held[f] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_BITS-1:0] value);
            case (index)
                CFG_DEADBAND_LOW:  deadband_low = value;
                CFG_DEADBAND_HIGH: deadband_high = value;
                CFG_AVG_INTERVAL:  average_interval = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_averages.size();
        endfunction

        function void note_sample(t_imu_in item);
            t_sample  smp [NFIELDS];
            t_imu_out res;
            int       mag;
            int       sum;
            logic     refreshed;
            smp[0] = item.accel_x;
            smp[1] = item.accel_y;
            smp[2] = item.accel_z;
            smp[3] = item.rate_x;
            smp[4] = item.rate_y;
            smp[5] = item.rate_z;
            smp[6] = item.temperature;
            refreshed = 1'b0;
            if (item.opcode == OP_PRIME) begin
                foreach (ring[k, f]) ring[k][f] = smp[f];
                foreach (held[f]) held[f] = smp[f];
            end else begin
                for (int f = 3; f < 6; f++) begin
                    mag = (smp[f] < 0) ? -int'(smp[f]) : int'(smp[f]);
                    if (mag < int'(deadband_low) || mag > int'(deadband_high)) begin
                        smp[f] = '0;
                    end
                end
                foreach (smp[f]) ring[slot][f] = smp[f];
                slot = (slot == SAMPLES - 1) ? 0 : slot + 1;
                if (interval_count < average_interval) begin
                    interval_count = interval_count + 16'd1;
                end else begin
                    interval_count = '0;
                    refreshed = 1'b1;
                    for (int f = 0; f < NFIELDS; f++) begin
                        sum = 0;
                        for (int k = 0; k < SAMPLES; k++) sum += int'(ring[k][f]);
                        held[f] = t_sample'(sum >>> SAMPLE_SHIFT);
                    end
                end
            end
            res.avg_accel_x     = held[0];
            res.avg_accel_y     = held[1];
            res.avg_accel_z     = held[2];
            res.avg_rate_x      = held[3];
            res.avg_rate_y      = held[4];
            res.avg_rate_z      = held[5];
            res.avg_temperature = held[6];
            res.refreshed       = refreshed;
            expected_averages.push_back(res);
        endfunction

        function void compare_field(string name, logic signed [16:0] want,
                                    logic signed [16:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_average(t_imu_out got);
            t_imu_out want;
            if (expected_averages.size() == 0) begin
                $error("result transaction arrived with no sample outstanding");
                mismatches++;
                return;
            end
            want = expected_averages.pop_front();
            compare_field("avg_accel_x", want.avg_accel_x, got.avg_accel_x);
            compare_field("avg_accel_y", want.avg_accel_y, got.avg_accel_y);
            compare_field("avg_accel_z", want.avg_accel_z, got.avg_accel_z);
            compare_field("avg_rate_x", want.avg_rate_x, got.avg_rate_x);
            compare_field("avg_rate_y", want.avg_rate_y, got.avg_rate_y);
            compare_field("avg_rate_z", want.avg_rate_z, got.avg_rate_z);
            compare_field("avg_temperature", want.avg_temperature, got.avg_temperature);
            compare_field("refreshed", want.refreshed, got.refreshed);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 o_in_ready;
    t_imu_in              in_data = '0;
    logic                 o_out_valid;
    logic                 out_ready = 1'b0;
    t_imu_out             o_out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]  cfg_data = '0;

    imu_average_predictor predictor = new();
    logic steady = 1'b0;
    int   ready_hold = 0;
    int   stuck_cycles = 0;

    imu_deadband_moving_average_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    always @(posedge clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            out_ready  <= 1'b0;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
            ready_hold <= pick_gap();
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            predictor.check_average(o_out_data);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || cfg_we) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic t_imu_in make_item(logic op, int ax, int ay, int az,
                                          int rx, int ry, int rz, int temp);
        t_imu_in item;
        item.opcode      = op;
        item.accel_x     = t_sample'(ax);
        item.accel_y     = t_sample'(ay);
        item.accel_z     = t_sample'(az);
        item.rate_x      = t_sample'(rx);
        item.rate_y      = t_sample'(ry);
        item.rate_z      = t_sample'(rz);
        item.temperature = t_sample'(temp);
        return item;
    endfunction

    function automatic t_sample near_limit(logic [CFG_BITS-1:0] limit);
        int v;
        v = int'(limit) + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        if ($urandom_range(0, 1) == 1) v = -v;
        if (v > 32767) v = 32767;
        return t_sample'(v);
    endfunction

    function automatic t_sample random_field();
        case ($urandom_range(0, 9))
            0: return t_sample'(32767);
            1: return t_sample'(-32768);
            2: return t_sample'(int'($urandom_range(0, 16)) - 8);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_sample random_rate();
        case ($urandom_range(0, 9))
            0, 1, 2: return near_limit(predictor.deadband_low);
            3, 4, 5: return near_limit(predictor.deadband_high);
            6: return t_sample'($urandom_range(0, 1) ? -32768 : 32767);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_imu_in random_item();
        t_imu_in item;
        item.opcode      = ($urandom_range(0, 24) == 0) ? OP_PRIME : OP_SAMPLE;
        item.accel_x     = random_field();
        item.accel_y     = random_field();
        item.accel_z     = random_field();
        item.rate_x      = random_rate();
        item.rate_y      = random_rate();
        item.rate_z      = random_rate();
        item.temperature = random_field();
        return item;
    endfunction

    task automatic send_item(input t_imu_in item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        predictor.note_sample(item);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (predictor.pending() != 0) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        predictor.set_reg(index, value);
    endtask

    task automatic set_config(input int low, input int high, input int interval);
        wait_drain();
        put_reg(CFG_DEADBAND_LOW, CFG_BITS'(low));
        put_reg(CFG_DEADBAND_HIGH, CFG_BITS'(high));
        put_reg(CFG_AVG_INTERVAL, CFG_BITS'(interval));
        put_reg(CFG_UNUSED, CFG_BITS'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial begin
        int low;
        int high;
        int interval;
        int pause_at;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(make_item(OP_SAMPLE, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_item(make_item(OP_SAMPLE, -32768, -32768, -32768, -32768, -32768, -32768,
                            -32768));
        send_item(make_item(OP_PRIME, 32767, -32768, 0, -32768, 32767, -1, 1));
        send_item(make_item(OP_SAMPLE, 1, -1, 3, -7, 9, 0, -5));

        set_config(100, 1000, 0);
        send_item(make_item(OP_SAMPLE, -3, 5, -7, 99, 100, -100, 11));
        send_item(make_item(OP_SAMPLE, 7, -9, 1, 1000, -1000, 1001, -13));
        send_item(make_item(OP_SAMPLE, -1, -1, -1, -1001, -99, 0, -1));
        send_item(make_item(OP_SAMPLE, 32767, -32768, 2, -32768, 32767, 555, 0));

        set_config(32768, 0, 0);
        send_item(make_item(OP_SAMPLE, 4, 4, 4, 0, 5, -32768, 4));

        set_config(0, 0, 1);
        send_item(make_item(OP_SAMPLE, -2, 2, -2, 0, 1, -1, 2));
        send_item(make_item(OP_SAMPLE, -2, 2, -2, -1, 0, 0, 2));

        set_config(32768, 32768, 0);
        send_item(make_item(OP_SAMPLE, 0, 0, 0, -32768, 32767, -32767, 0));
        send_item(make_item(OP_PRIME, -3, -3, 3, -3, 3, -3, -32768));
        send_item(make_item(OP_SAMPLE, -4, -2, 4, -32768, -32768, 32767, 32767));
        send_item(make_item(OP_SAMPLE, -19, 21, -17, 5, 6, 7, -23));

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin low = 0; high = 32768; interval = 0; end
                1: begin low = $urandom_range(0, 500); high = 32768; interval = 65535; end
                2: begin low = 32768; high = 32768; interval = 2; end
                3: begin low = 0; high = 0; interval = 15; end
                4: begin low = 20000; high = 300; interval = 1; end
                default: begin
                    low = $urandom_range(0, 3000);
                    high = $urandom_range(low, 32768);
                    interval = $urandom_range(0, 20);
                end
            endcase
            set_config(low, high, interval);
            steady = (phase % 4 == 2);
            pause_at = $urandom_range(10, PHASE_ITEMS - 10);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == pause_at) wait_drain();
                send_item(random_item());
            end
        end

        wait_drain();
        repeat (150) @(posedge clk);
        if (predictor.mismatches == 0 && predictor.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/imu_dma_pkg.sv
sv/imu_dma_ring.sv
sv/imu_dma_alu.sv
sv/imu_deadband_moving_average_unit.sv
sim/tb_imu_deadband_moving_average_unit.sv
